// ----- design/asn_pkg.sv -----
package asn_pkg;

    localparam int AMP_W         = 16;
    localparam int SUM_W         = 22;
    localparam int FRAC_W        = 16;
    localparam int NORM_W        = 17;
    localparam int POS_W         = 6;
    localparam int OUT_TDATA_W   = 24;
    localparam int MAX_FRAME_DEF = 64;

    localparam logic [NORM_W-1:0] ONE_Q16 = NORM_W'(1) << FRAC_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_CALC,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ----- design/amplitude_sum_normalizer.sv -----
// Channel   | Direction | Words carried
// s_axis    | in        | tdata: amplitude[15:0]; tlast: frame end
// m_axis    | out       | tdata: normalized[16:0], position[22:17], 0[23]; tlast: run end
// cfg       | in        | data: reference sum[21:0]
//
// Loading accepts one input word per cycle; s_axis is ready only while loading.
// Closing a frame starts the emit pass: per word a memory read state, a setup
// state that starts the shared restoring divider (one quotient bit per cycle), a
// divider wait state and an output state; a zero-sum frame skips the divider.
// Reset (synchronous, active low) clears sum, fill count and sequencer; the
// sample memory is not cleared. m_axis stalls hold the sequencer in place.
module amplitude_sum_normalizer #(
    parameter int MAX_FRAME = asn_pkg::MAX_FRAME_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [asn_pkg::AMP_W-1:0]           i_s_axis_tdata,  // amplitude
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [asn_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,  // normalized, position, pad
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [asn_pkg::SUM_W-1:0]           i_cfg_data
);

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int FW = $clog2(MAX_FRAME + 1);

    asn_pkg::t_state               r_state, n_state;
    logic [asn_pkg::AMP_W-1:0]     r_mem [MAX_FRAME];
    logic [asn_pkg::AMP_W-1:0]     r_rd_data;
    logic [asn_pkg::SUM_W-1:0]     r_ref;
    logic [asn_pkg::SUM_W-1:0]     r_sum, n_sum;
    logic [asn_pkg::SUM_W-1:0]     r_divisor, n_divisor;
    logic [FW-1:0]                 r_fill, n_fill;
    logic [FW-1:0]                 r_count, n_count;
    logic [AW-1:0]                 r_idx, n_idx;
    logic                          r_zero, n_zero;
    logic [asn_pkg::NORM_W-1:0]    r_norm, n_norm;

    logic                          w_in_acc;
    logic                          w_last_idx;
    logic [asn_pkg::SUM_W-1:0]     w_sum_add;
    logic [FW-1:0]                 w_fill_inc;
    logic [asn_pkg::NORM_W-1:0]    w_quot;
    logic                          w_div_start;
    logic                          w_div_done;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sum_add  = r_sum + asn_pkg::SUM_W'(i_s_axis_tdata);
    assign w_fill_inc = r_fill + 1'b1;
    assign w_last_idx = FW'(r_idx) == (r_count - 1'b1);

    asn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rd_data),
        .i_divisor  (r_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mem[r_fill[AW-1:0]] <= i_s_axis_tdata;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asn_pkg::S_LOAD;
            r_ref   <= '0;
            r_sum   <= '0;
            r_fill  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_zero  <= n_zero;
            if (i_cfg_valid) begin
                r_ref <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_divisor <= n_divisor;
        r_norm    <= n_norm;
    end

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_fill      = r_fill;
        n_count     = r_count;
        n_idx       = r_idx;
        n_zero      = r_zero;
        n_divisor   = r_divisor;
        n_norm      = r_norm;
        w_div_start = 1'b0;
        case (r_state)
            asn_pkg::S_LOAD: begin
                if (w_in_acc) begin
                    n_sum  = w_sum_add;
                    n_fill = w_fill_inc;
                    if (i_s_axis_tlast || w_fill_inc == FW'(MAX_FRAME)) begin
                        n_count   = w_fill_inc;
                        n_idx     = '0;
                        n_zero    = w_sum_add == '0;
                        n_divisor = (w_sum_add > r_ref) ? w_sum_add : r_ref;
                        n_state   = asn_pkg::S_READ;
                    end
                end
            end
            asn_pkg::S_READ: begin
                n_state = asn_pkg::S_CALC;
            end
            asn_pkg::S_CALC: begin
                if (r_zero) begin
                    n_norm  = asn_pkg::NORM_W'(r_rd_data);
                    n_state = asn_pkg::S_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = asn_pkg::S_DIV;
                end
            end
            asn_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_norm  = (w_quot > asn_pkg::ONE_Q16) ? asn_pkg::ONE_Q16 : w_quot;
                    n_state = asn_pkg::S_OUT;
                end
            end
            asn_pkg::S_OUT: begin
                if (i_m_axis_tready) begin
                    if (w_last_idx) begin
                        n_sum   = '0;
                        n_fill  = '0;
                        n_state = asn_pkg::S_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = asn_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state = asn_pkg::S_LOAD;
            end
        endcase
    end

    assign o_s_axis_tready = r_state == asn_pkg::S_LOAD;
    assign o_m_axis_tvalid = r_state == asn_pkg::S_OUT;
    assign o_m_axis_tdata  = {1'b0, asn_pkg::POS_W'(r_idx), r_norm};
    assign o_m_axis_tlast  = w_last_idx;
    assign o_cfg_ready     = 1'b1;

endmodule

// ----- design/asn_div.sv -----
module asn_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [asn_pkg::AMP_W-1:0]       i_dividend,
    input  logic [asn_pkg::SUM_W-1:0]       i_divisor,
    output logic                            o_done,
    output logic [asn_pkg::NORM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(asn_pkg::FRAC_W + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [asn_pkg::SUM_W-1:0]     r_rem;
    logic [asn_pkg::SUM_W-1:0]     r_div;
    logic [asn_pkg::NORM_W-1:0]    r_quot;

    logic [asn_pkg::SUM_W-1:0]     w_num;
    logic [asn_pkg::SUM_W:0]       w_shift;
    logic                          w_ge;

    assign w_num   = asn_pkg::SUM_W'(i_dividend);
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(asn_pkg::FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            if (w_num >= i_divisor) begin
                r_rem  <= w_num - i_divisor;
                r_quot <= asn_pkg::NORM_W'(1);
            end else begin
                r_rem  <= w_num;
                r_quot <= '0;
            end
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem  <= asn_pkg::SUM_W'(w_shift - {1'b0, r_div});
                r_quot <= {r_quot[asn_pkg::NORM_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift[asn_pkg::SUM_W-1:0];
                r_quot <= {r_quot[asn_pkg::NORM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
